/* hdl/mandelbrot_escape_time_pixel_macros.svh */
// Assertion macros for the escape-time pixel engine.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// same-cycle implication
`define MANDEL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MANDEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mandel_pkg.sv */
// Shared types, constants and colour ramp for the escape-time pixel engine.
// No dependencies.
package mandel_pkg;

    localparam int COLOR_ENTRIES = 64;
    localparam int CIDX_W        = $clog2(COLOR_ENTRIES);
    localparam int COORD_W       = 32;
    localparam int ITER_W        = 16;
    localparam int COUNT_W       = ITER_W + 1;
    localparam int TOTAL_W       = 48;
    localparam int COLOR_W       = 24;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int FRAC_BITS     = 28;
    localparam int OUT_DATA_W    = 96;

    localparam logic [1:0] REG_X_START  = 2'd0;
    localparam logic [1:0] REG_X_STEP   = 2'd1;
    localparam logic [1:0] REG_MAX_ITER = 2'd2;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd256;

    localparam logic [1:0] BAND_BLUE  = 2'b00;
    localparam logic [1:0] BAND_GREEN = 2'b01;
    localparam logic [1:0] BAND_RED   = 2'b10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_FIN
    } mandel_state_t;

    typedef struct packed {
        logic load;
        logic iter;
        logic emit;
    } mandel_cmd_t;

    typedef struct packed {
        logic finish;
    } mandel_stat_t;

    function automatic logic [COLOR_W-1:0] ramp_color(input logic [CIDX_W-1:0] idx);
        logic [3:0]         lvl;
        logic [COLOR_W-1:0] col;
        lvl = idx[3:0];
        case (idx[5:4])
            BAND_BLUE:  col = {16'h0000, lvl, 4'h0};
            BAND_GREEN: col = {8'h00, lvl, 12'h000};
            BAND_RED:   col = {lvl, 20'h00000};
            default:    col = {lvl, 12'h000, lvl, 4'h0};
        endcase
        return col;
    endfunction

endpackage

/* hdl/mandel_ctrl.sv */
// Sequencer for the escape-time pixel engine: handshakes and iteration steps.
// Depends on mandel_pkg.
module mandel_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  mandel_pkg::mandel_stat_t  stat,
    output mandel_pkg::mandel_cmd_t   cmd
);
    import mandel_pkg::*;

    mandel_state_t state_reg, state_next;
    logic          out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
                state_next = ST_UPD;
            ST_UPD:
            begin
                if (stat.finish)
                    state_next = ST_FIN;
                else
                begin
                    cmd.iter   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/mandel_dp.sv */
// Datapath: coordinate tracking, complex square step, escape test, colour and totals.
// Depends on mandel_pkg.
module mandel_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_addr,
    input  logic [mandel_pkg::COORD_W-1:0]         cfg_data,
    input  logic [mandel_pkg::COORD_W-1:0]         c_imag,
    input  logic                                   row_start,
    input  mandel_pkg::mandel_cmd_t                cmd,
    output mandel_pkg::mandel_stat_t               stat,
    output logic [mandel_pkg::COLOR_W-1:0]         pixel_color,
    output logic [mandel_pkg::COUNT_W-1:0]         iter_count,
    output logic [mandel_pkg::TOTAL_W-1:0]         total_iterations
);
    import mandel_pkg::*;

    logic [COORD_W-1:0]        x_start_reg, x_step_reg;
    logic [ITER_W-1:0]         max_iter_reg;
    logic [COORD_W-1:0]        real_coord_reg;
    logic [TOTAL_W-1:0]        total_reg, total_next;

    logic signed [COORD_W-1:0] ci_reg;
    logic signed [COORD_W-1:0] ar_reg, ai_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [PROD_W-1:0]  rr_reg, ii_reg, ri_reg;

    logic [COLOR_W-1:0]        color_reg;
    logic [COUNT_W-1:0]        cnt_out_reg;
    logic [TOTAL_W-1:0]        tot_out_reg;

    logic signed [PROD_W-1:0]  re_wide, im_wide, cr_wide, ci_wide;
    logic signed [COORD_W-1:0] nr, ni;
    logic [PROD_W-1:0]         mag;
    logic                      bounded;
    logic [TOTAL_W:0]          total_sum;
    logic [COLOR_W-1:0]        color_next;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[PROD_W-1:COORD_W-1] == '0 || v[PROD_W-1:COORD_W-1] == '1)
            r = v[COORD_W-1:0];
        else if (v[PROD_W-1])
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = {1'b0, {(COORD_W-1){1'b1}}};
        return r;
    endfunction

    // configuration and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg    <= '0;
            x_step_reg     <= '0;
            max_iter_reg   <= MAX_ITER_RST;
            real_coord_reg <= '0;
            total_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_X_START:  x_start_reg  <= cfg_data;
                    REG_X_STEP:   x_step_reg   <= cfg_data;
                    REG_MAX_ITER: max_iter_reg <= cfg_data[ITER_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.load)
                real_coord_reg <= row_start ? x_start_reg : real_coord_reg + x_step_reg;
            if (cmd.emit)
                total_reg <= total_next;
        end
    end

    // iteration registers
    always_ff @(posedge clk)
    begin
        rr_reg <= ar_reg * ar_reg;
        ii_reg <= ai_reg * ai_reg;
        ri_reg <= ar_reg * ai_reg;
        if (cmd.load)
        begin
            ci_reg    <= c_imag;
            ar_reg    <= '0;
            ai_reg    <= '0;
            count_reg <= '0;
        end
        else if (cmd.iter)
        begin
            ar_reg    <= nr;
            ai_reg    <= ni;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            color_reg   <= color_next;
            cnt_out_reg <= count_reg;
            tot_out_reg <= total_next;
        end
    end

    always_comb
    begin
        cr_wide = {{(PROD_W-COORD_W){real_coord_reg[COORD_W-1]}}, real_coord_reg};
        ci_wide = {{(PROD_W-COORD_W){ci_reg[COORD_W-1]}}, ci_reg};
        re_wide = ((rr_reg - ii_reg) >>> FRAC_BITS) - cr_wide;
        im_wide = (ri_reg >>> (FRAC_BITS - 1)) - ci_wide;
        nr      = sat_coord(re_wide);
        ni      = sat_coord(im_wide);
        // |a|^2 < 4 in Q8.56
        mag     = rr_reg + ii_reg;
        bounded = (mag[PROD_W-1:2*FRAC_BITS+2] == '0);
        stat.finish = (count_reg != '0)
                      && ((count_reg > {1'b0, max_iter_reg}) || !bounded);

        color_next = (count_reg >= {1'b0, max_iter_reg}) ? '0
                                                         : ramp_color(count_reg[CIDX_W-1:0]);
        total_sum  = {1'b0, total_reg} + {{(TOTAL_W+1-COUNT_W){1'b0}}, count_reg};
        total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    end

    assign pixel_color      = color_reg;
    assign iter_count       = cnt_out_reg;
    assign total_iterations = tot_out_reg;

endmodule

/* hdl/mandelbrot_escape_time_pixel.sv */
// Escape-time pixel engine: one pixel item in, one colour/count/total item out.
// Each complex step runs a multiply state, which feeds the registered 32x32 multipliers, then
// the update/escape stage; a new pixel is accepted only after the last result is emitted.
// Reset (async, active low): idle, no output, x_start/x_step 0, max_iter 256, totals 0.
module mandelbrot_escape_time_pixel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] c_imag
    input  logic        s_axis_tuser,   // [0] row_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // [23:0] pixel_color, [40:24] iter_count,
                                        // [88:41] total_iterations, [95:89] zero
);
    import mandel_pkg::*;

    `include "mandelbrot_escape_time_pixel_macros.svh"

    mandel_cmd_t            cmd;
    mandel_stat_t           stat;
    logic [COLOR_W-1:0]     pixel_color;
    logic [COUNT_W-1:0]     iter_count;
    logic [TOTAL_W-1:0]     total_iterations;

    mandel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mandel_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data),
        .c_imag           (s_axis_tdata),
        .row_start        (s_axis_tuser),
        .cmd              (cmd),
        .stat             (stat),
        .pixel_color      (pixel_color),
        .iter_count       (iter_count),
        .total_iterations (total_iterations)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-COLOR_W-COUNT_W-TOTAL_W){1'b0}},
                           total_iterations, iter_count, pixel_color};

    `MANDEL_ASSERT_NOW(a_no_overwrite, cmd.emit, !m_axis_tvalid || m_axis_tready, "result overwritten")
    `MANDEL_ASSERT_NOW(a_count_nonzero, m_axis_tvalid, iter_count != '0, "zero iteration count")
    `MANDEL_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready while busy")

endmodule

/* test/tb_mandelbrot_escape_time_pixel.sv */
// Self-checking testbench for the escape-time pixel engine: directed table, then random rows.
// Predicts colour, count and running total per pixel item and checks each output item in order.
// Depends on mandel_pkg and mandelbrot_escape_time_pixel.
module tb_mandelbrot_escape_time_pixel;
    timeunit 1ns;
    timeprecision 1ps;

    import mandel_pkg::*;

    localparam int RANDOM_PIXELS = 1900;
    localparam int TABLE_ROWS    = 35;

    typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic        row_start;
        logic        typed;
        logic [23:0] color;
        logic [16:0] count;
    } stim_row_t;

    typedef struct packed {
        logic [23:0] color;
        logic [16:0] count;
        logic [47:0] total;
    } pixel_result_t;

    // typed rows: after reset, coordinate extremes, iteration limit extremes
    localparam stim_row_t DIRECTED [TABLE_ROWS] = '{
        '{ROW_PIX, REG_X_START,  32'h0000_0000, 1'b1, 1'b1, 24'h00_0000, 17'd257},
        '{ROW_PIX, REG_X_START,  32'h8000_0000, 1'b0, 1'b1, 24'h00_0010, 17'd1},
        '{ROW_PIX, REG_X_START,  32'h7fff_ffff, 1'b0, 1'b1, 24'h00_0010, 17'd1},
        '{ROW_CFG, REG_X_START,  32'h8000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0000_0000, 1'b1, 1'b1, 24'h00_0010, 17'd1},
        '{ROW_CFG, REG_X_STEP,   32'h7fff_ffff, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_CFG, REG_X_START,  32'h7fff_ffff, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0000_0000, 1'b1, 1'b1, 24'h00_0010, 17'd1},
        '{ROW_PIX, REG_X_START,  32'h0000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_CFG, REG_MAX_ITER, 32'h0000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_CFG, REG_X_START,  32'h0000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_CFG, REG_X_STEP,   32'h0000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0000_0000, 1'b1, 1'b1, 24'h00_0000, 17'd1},
        '{ROW_PIX, REG_X_START,  32'h1000_0000, 1'b0, 1'b1, 24'h00_0000, 17'd1},
        '{ROW_CFG, REG_MAX_ITER, 32'h0000_0001, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0000_0000, 1'b1, 1'b1, 24'h00_0000, 17'd2},
        '{ROW_CFG, REG_MAX_ITER, 32'h0000_ffff, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0000_0000, 1'b1, 1'b1, 24'h00_0000, 17'd65536},
        '{ROW_PIX, REG_X_START,  32'h2000_0000, 1'b0, 1'b1, 24'h00_0010, 17'd1},
        '{ROW_CFG, REG_MAX_ITER, 32'h0000_0040, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_CFG, REG_X_START,  32'hf800_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_CFG, REG_X_STEP,   32'h0200_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0400_0000, 1'b1, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0400_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0400_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0400_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0400_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'h0400_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'hf000_0000, 1'b1, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'hf000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'hf000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'hf000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'hf000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0},
        '{ROW_PIX, REG_X_START,  32'hf000_0000, 1'b0, 1'b0, 24'h00_0000, 17'd0}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_addr      = '0;
    logic [31:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] c_imag
    logic        s_axis_tuser  = 1'b0; // [0] row_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;         // [23:0] pixel_color, [40:24] iter_count,
                                       // [88:41] total_iterations

    // register mirrors and engine state
    logic [31:0] x_start_r  = '0;
    logic [31:0] x_step_r   = '0;
    logic [15:0] max_iter_r = MAX_ITER_RST;
    logic [31:0] real_acc   = '0;
    logic [47:0] iter_sum   = '0;

    pixel_result_t awaited_pixels [$];
    int unsigned   faults = 0;
    int            stall_left = 0;
    bit            steady = 1'b0;

    mandelbrot_escape_time_pixel u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    function automatic longint clamp32(input longint v);
        if (v > 64'sh7fff_ffff)
            return 64'sh7fff_ffff;
        if (v < -64'sh8000_0000)
            return -64'sh8000_0000;
        return v;
    endfunction

    // advance the real coordinate, run the orbit, colour it and update the total
    function automatic pixel_result_t escape_pixel(input logic [31:0] c_im, input logic rs);
        longint        cr;
        longint        ci;
        longint        ar;
        longint        ai;
        longint        nr;
        longint        ni;
        logic [63:0]   mag;
        int            count;
        bit            bounded;
        logic [3:0]    shade;
        pixel_result_t res;
        if (rs)
            real_acc = x_start_r;
        else
            real_acc = real_acc + x_step_r;
        cr = longint'($signed(real_acc));
        ci = longint'($signed(c_im));
        ar = 0;
        ai = 0;
        count = 0;
        do
        begin
            nr = clamp32(((ar * ar - ai * ai) >>> FRAC_BITS) - cr);
            ni = clamp32(((ar * ai) >>> (FRAC_BITS - 1)) - ci);
            ar = nr;
            ai = ni;
            count++;
            mag = $unsigned(ar * ar) + $unsigned(ai * ai);
            bounded = mag < (64'd4 << (2 * FRAC_BITS));
        end
        while (count <= int'(max_iter_r) && bounded);
        shade = count[3:0];
        if (count >= int'(max_iter_r))
            res.color = '0;
        else
        begin
            case (count[5:4])
                BAND_BLUE:  res.color = 24'(shade) << 4;
                BAND_GREEN: res.color = 24'(shade) << 12;
                BAND_RED:   res.color = 24'(shade) << 20;
                default:    res.color = (24'(shade) << 20) | (24'(shade) << 4);
            endcase
        end
        if (iter_sum > 48'hffff_ffff_ffff - 48'(count))
            iter_sum = '1;
        else
            iter_sum = iter_sum + 48'(count);
        res.count = 17'(count);
        res.total = iter_sum;
        return res;
    endfunction

    function automatic logic [31:0] near_coord(input int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic void note_fault(input string msg);
        faults++;
        if (faults <= 10)
            $display("%t mismatch: %s", $realtime, msg);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_X_START:  x_start_r = val;
            REG_X_STEP:   x_step_r = val;
            REG_MAX_ITER: max_iter_r = val[15:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [31:0] c_im, input logic rs, input logic typed,
                              input logic [23:0] t_color, input logic [16:0] t_count);
        int            gap;
        pixel_result_t want;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c_im;
        s_axis_tuser  <= rs;
        do @(posedge clk); while (!s_axis_tready);
        want = escape_pixel(c_im, rs);
        if (typed)
        begin
            want.color = t_color;
            want.count = t_count;
        end
        awaited_pixels.push_back(want);
    endtask

    // engine idle: every result back, then a few spare cycles
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          sent;
        int          len;
        int          row_left;
        logic [31:0] row_im;
        logic [31:0] ci;
        logic        rs;
        logic [31:0] lim;
        sent = 0;
        row_left = 0;
        row_im = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < TABLE_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
            begin
                settle();
                write_reg(DIRECTED[r].reg_idx, DIRECTED[r].value);
            end
            else
                send_pixel(DIRECTED[r].value, DIRECTED[r].row_start, DIRECTED[r].typed,
                           DIRECTED[r].color, DIRECTED[r].count);
        end

        while (sent < RANDOM_PIXELS)
        begin
            settle();
            steady = ($urandom_range(0, 3) == 0);
            write_reg(REG_X_START, ($urandom_range(0, 7) == 0) ? $urandom() :
                                   near_coord(32'h2800_0000));
            write_reg(REG_X_STEP, ($urandom_range(0, 7) == 0) ? $urandom() :
                                  near_coord(32'h0200_0000));
            case ($urandom_range(0, 9))
                0:       lim = 256;
                1:       lim = $urandom_range(65, 300);
                2:       lim = $urandom_range(0, 2);
                default: lim = $urandom_range(1, 64);
            endcase
            write_reg(REG_MAX_ITER, lim);
            len = $urandom_range(30, 80);
            for (int k = 0; k < len && sent < RANDOM_PIXELS; k++)
            begin
                rs = (row_left == 0) || ($urandom_range(0, 31) == 0);
                if (row_left == 0)
                begin
                    row_left = $urandom_range(4, 24);
                    row_im = ($urandom_range(0, 7) == 0) ? $urandom() :
                             near_coord(32'h2000_0000);
                end
                row_left--;
                ci = ($urandom_range(0, 9) == 0) ? $urandom() : row_im;
                send_pixel(ci, rs, 1'b0, '0, '0);
                sent++;
            end
        end

        settle();
        repeat (16) @(posedge clk);
        if (faults == 0)
            $display("tb_mandelbrot_escape_time_pixel: PASS");
        else
            $display("tb_mandelbrot_escape_time_pixel: FAIL");
        $finish;
    end

    // output side: check each item, then hold tready low for a drawn number of valid cycles
    always @(posedge clk)
    begin
        pixel_result_t got;
        pixel_result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b1;
            stall_left = 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            got.color = m_axis_tdata[23:0];
            got.count = m_axis_tdata[40:24];
            got.total = m_axis_tdata[88:41];
            if (awaited_pixels.size() == 0)
                note_fault($sformatf("unexpected item colour %h count %0d total %0d",
                                     got.color, got.count, got.total));
            else
            begin
                want = awaited_pixels.pop_front();
                if (got != want)
                    note_fault($sformatf({"colour %h/%h count %0d/%0d total %0d/%0d",
                                          " (expected/actual)"},
                                         want.color, got.color, want.count, got.count,
                                         want.total, got.total));
            end
            stall_left = steady ? 0 : $urandom_range(0, 4);
            m_axis_tready <= (stall_left == 0);
        end
        else if (!m_axis_tready && m_axis_tvalid)
        begin
            stall_left--;
            if (stall_left <= 0)
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        #100_000_000;
        $display("tb_mandelbrot_escape_time_pixel: FAIL");
        $finish;
    end

endmodule
